// ===== rtl/bms_pkg.sv =====
`timescale 1ns / 1ps
package bms_pkg;

    localparam int MAX_POINTS_DEF = 4;
    localparam int MAX_LEVELS_DEF = 4;
    localparam logic [2:0] LEVELS_RESET = 3'd3;
    localparam logic REG_LEVELS = 1'b0;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [15:0] order_key;
        logic               has_point;
        logic               last_point;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               overflow;
        logic               end_of_curve;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_FILL,
        ST_RD_ISSUE,
        ST_RD_CAP,
        ST_WR_LEFT,
        ST_WR_RIGHT,
        ST_OUT_ISSUE,
        ST_OUT_CAP,
        ST_OUT_HOLD
    } state_t;

    // floor((a+b)/2) on the exact 33-bit sum
    function automatic logic signed [31:0] mid(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        logic signed [32:0] sum;
        sum = {a[31], a} + {b[31], b};
        return sum[32:1];
    endfunction

endpackage

// ===== rtl/bms_ram.sv =====
`timescale 1ns / 1ps
module bms_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 98
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/bms_pts.sv =====
`timescale 1ns / 1ps
module bms_pts import bms_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int CW = $clog2(MAX_POINTS + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load,
    input  logic                     clear,
    input  logic signed [31:0]       in_x,
    input  logic signed [31:0]       in_y,
    input  logic signed [15:0]       in_key,
    output logic [CW-1:0]            count,
    output logic                     dropped,
    output logic signed [31:0]       px [MAX_POINTS],
    output logic signed [31:0]       py [MAX_POINTS]
);
    logic signed [31:0] x_reg [MAX_POINTS];
    logic signed [31:0] y_reg [MAX_POINTS];
    logic signed [15:0] key_reg [MAX_POINTS];
    logic signed [31:0] x_next [MAX_POINTS];
    logic signed [31:0] y_next [MAX_POINTS];
    logic signed [15:0] key_next [MAX_POINTS];
    logic [MAX_POINTS-1:0] le;
    logic [CW-1:0] count_reg;
    logic dropped_reg;

    // sorted row: entries at or below the new key stay, the rest move up one
    always_comb begin
        for (int i = 0; i < MAX_POINTS; i++) begin
            le[i] = (CW'(i) < count_reg) && (key_reg[i] <= in_key);
        end
        for (int i = 0; i < MAX_POINTS; i++) begin
            if (le[i]) begin
                x_next[i] = x_reg[i];
                y_next[i] = y_reg[i];
                key_next[i] = key_reg[i];
            end else if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
                x_next[i] = in_x;
                y_next[i] = in_y;
                key_next[i] = in_key;
            end else begin
                x_next[i] = x_reg[(i == 0) ? 0 : i - 1];
                y_next[i] = y_reg[(i == 0) ? 0 : i - 1];
                key_next[i] = key_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && count_reg < CW'(MAX_POINTS)) begin
            x_reg <= x_next;
            y_reg <= y_next;
            key_reg <= key_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            dropped_reg <= 1'b0;
        end else if (clear) begin
            count_reg <= '0;
            dropped_reg <= 1'b0;
        end else if (load) begin
            if (count_reg < CW'(MAX_POINTS)) begin
                count_reg <= count_reg + CW'(1);
            end else begin
                dropped_reg <= 1'b1;
            end
        end
    end

    assign count = count_reg;
    assign dropped = dropped_reg;
    assign px = x_reg;
    assign py = y_reg;
endmodule

// ===== rtl/bms_cfg.sv =====
`timescale 1ns / 1ps
module bms_cfg import bms_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [2:0]  levels
);
    logic [2:0] levels_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg <= LEVELS_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_LEVELS) begin
            levels_reg <= pwdata[2:0];
        end
    end

    assign prdata = (paddr[2] == REG_LEVELS) ? {29'd0, levels_reg} : 32'd0;
    assign pready = 1'b1;
    assign levels = levels_reg;
endmodule

// ===== rtl/bezier_midpoint_subdivision_top.sv =====
`timescale 1ns / 1ps
// flow: a last beat starts a fill of the curve ram with the sorted points, then
// each sub-curve of each level is read and its halves written on the curve ram
// port, then each result beat is read from the ram and held while m_ready is low
// throughput: one run at a time; no input beat is taken until the end beat leaves
// reset: synchronous active-low; clears point count, drop flag, fsm, levels=3
module bezier_midpoint_subdivision_top import bms_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CURVE_MAX = (MAX_POINTS - 1) * (2 ** MAX_LEVELS) + 1;
    localparam int DEPTH = 2 * CURVE_MAX;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int KW = $clog2(MAX_POINTS);
    localparam int SW = MAX_LEVELS + 1;

    state_t state_reg, state_next;

    logic [2:0] cfg_levels;
    logic [CW-1:0] n;
    logic dropped;
    logic signed [31:0] px [MAX_POINTS];
    logic signed [31:0] py [MAX_POINTS];
    logic s_beat, m_beat, clear;

    logic signed [31:0] work_x_reg [MAX_POINTS];
    logic signed [31:0] work_y_reg [MAX_POINTS];
    logic [2:0] lv_reg, lv_cnt_reg, eff;
    logic [SW-1:0] segs_reg, seg_reg;
    logic [AW-1:0] src_reg, oi_reg, total;
    logic [CW-1:0] k_reg, r_reg, last;
    logic bank_reg;
    out_beat_t m_data_reg;
    logic m_valid_reg;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr, rbase, wbase, dst, nm1;
    logic [63:0] ram_wdata, ram_rdata;
    logic fill_done, row_done, seg_done, lvl_done, run_end;

    bms_cfg u_cfg (
        .aclk(aclk), .aresetn(aresetn), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .levels(cfg_levels)
    );

    bms_pts #(.MAX_POINTS(MAX_POINTS), .CW(CW)) u_pts (
        .aclk(aclk), .aresetn(aresetn), .load(s_beat && s_data.has_point),
        .clear(clear), .in_x(s_data.point_x), .in_y(s_data.point_y),
        .in_key(s_data.order_key), .count(n), .dropped(dropped),
        .px(px), .py(py)
    );

    bms_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    assign s_ready = (state_reg == ST_LOAD);
    assign s_beat = s_valid && s_ready;
    assign m_beat = m_valid_reg && m_ready;
    assign run_end = m_beat && m_data_reg.end_of_curve;
    assign clear = run_end;

    assign eff = (n < CW'(2)) ? 3'd0 : lv_reg;
    assign nm1 = AW'(n) - AW'(1);
    assign total = (n < CW'(2)) ? AW'(1) : AW'(nm1 << eff) + AW'(1);
    assign last = n - CW'(1) - r_reg;
    assign rbase = bank_reg ? AW'(CURVE_MAX) : '0;
    assign wbase = bank_reg ? '0 : AW'(CURVE_MAX);
    assign dst = AW'({src_reg, 1'b0});

    assign fill_done = (n == '0) || (k_reg == n - CW'(1));
    assign row_done = (r_reg == n - CW'(1));
    assign seg_done = (seg_reg + SW'(1) == segs_reg);
    assign lvl_done = (lv_cnt_reg + 3'd1 == eff);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_beat && s_data.last_point) state_next = ST_FILL;
            end
            ST_FILL: begin
                if (fill_done) state_next = (eff == 3'd0) ? ST_OUT_ISSUE : ST_RD_ISSUE;
            end
            ST_RD_ISSUE: state_next = ST_RD_CAP;
            ST_RD_CAP: begin
                state_next = (k_reg == n - CW'(1)) ? ST_WR_LEFT : ST_RD_ISSUE;
            end
            ST_WR_LEFT: state_next = ST_WR_RIGHT;
            ST_WR_RIGHT: begin
                if (!row_done) state_next = ST_WR_LEFT;
                else if (seg_done && lvl_done) state_next = ST_OUT_ISSUE;
                else state_next = ST_RD_ISSUE;
            end
            ST_OUT_ISSUE: state_next = ST_OUT_CAP;
            ST_OUT_CAP: state_next = ST_OUT_HOLD;
            ST_OUT_HOLD: begin
                if (run_end) state_next = ST_LOAD;
                else if (m_beat) state_next = ST_OUT_ISSUE;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // curve ram port
    always_comb begin
        ram_we = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        unique case (state_reg)
            ST_FILL: begin
                ram_we = 1'b1;
                ram_waddr = AW'(k_reg);
                ram_wdata = (n == '0) ? 64'd0 : {px[k_reg[KW-1:0]], py[k_reg[KW-1:0]]};
            end
            ST_RD_ISSUE: ram_raddr = rbase + src_reg + AW'(k_reg);
            ST_WR_LEFT: begin
                ram_we = 1'b1;
                ram_waddr = wbase + dst + AW'(r_reg);
                ram_wdata = {work_x_reg[0], work_y_reg[0]};
            end
            ST_WR_RIGHT: begin
                ram_we = 1'b1;
                ram_waddr = wbase + dst + nm1 + AW'(last);
                ram_wdata = {work_x_reg[last[KW-1:0]], work_y_reg[last[KW-1:0]]};
            end
            ST_OUT_ISSUE: ram_raddr = rbase + oi_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT_CAP) m_valid_reg <= 1'b1;
            else if (m_beat) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_LOAD: begin
                lv_reg <= (cfg_levels > 3'(MAX_LEVELS)) ? 3'(MAX_LEVELS) : cfg_levels;
                k_reg <= '0;
            end
            ST_FILL: begin
                k_reg <= fill_done ? '0 : k_reg + CW'(1);
                bank_reg <= 1'b0;
                lv_cnt_reg <= '0;
                seg_reg <= '0;
                segs_reg <= SW'(1);
                src_reg <= '0;
                oi_reg <= '0;
            end
            ST_RD_CAP: begin
                work_x_reg[k_reg[KW-1:0]] <= $signed(ram_rdata[63:32]);
                work_y_reg[k_reg[KW-1:0]] <= $signed(ram_rdata[31:0]);
                k_reg <= k_reg + CW'(1);
                r_reg <= '0;
            end
            ST_WR_RIGHT: begin
                // collapse one row of the triangle
                for (int i = 0; i < MAX_POINTS - 1; i++) begin
                    if (CW'(i) < last) begin
                        work_x_reg[i] <= mid(work_x_reg[i], work_x_reg[i + 1]);
                        work_y_reg[i] <= mid(work_y_reg[i], work_y_reg[i + 1]);
                    end
                end
                r_reg <= r_reg + CW'(1);
                if (row_done) begin
                    k_reg <= '0;
                    if (seg_done) begin
                        bank_reg <= ~bank_reg;
                        lv_cnt_reg <= lv_cnt_reg + 3'd1;
                        segs_reg <= SW'({segs_reg, 1'b0});
                        seg_reg <= '0;
                        src_reg <= '0;
                    end else begin
                        seg_reg <= seg_reg + SW'(1);
                        src_reg <= src_reg + nm1;
                    end
                end
            end
            ST_OUT_CAP: begin
                m_data_reg.out_x <= $signed(ram_rdata[63:32]);
                m_data_reg.out_y <= $signed(ram_rdata[31:0]);
                m_data_reg.overflow <= dropped;
                m_data_reg.end_of_curve <= (oi_reg == total - AW'(1));
            end
            ST_OUT_HOLD: begin
                if (m_beat) oi_reg <= oi_reg + AW'(1);
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    a_valid_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> state_reg == ST_OUT_HOLD)
        else $error("result valid outside hold state");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid_reg)
        else $error("input taken while a result is pending");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        run_end |=> (state_reg == ST_LOAD) && (n == '0) && !dropped)
        else $error("load state not restored after end beat");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT_HOLD) |-> oi_reg < total)
        else $error("output index past polyline length");
endmodule
